// ===== hdl/circular_row_pad_grad_accumulate_unit_assert.svh =====
// Assertion macros for the circular row padding gradient accumulator.
`ifndef CIRCULAR_ROW_PAD_GRAD_ACCUMULATE_UNIT_ASSERT_SVH
`define CIRCULAR_ROW_PAD_GRAD_ACCUMULATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CRPGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crpga: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CRPGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crpga: next-cycle check failed");
`else
`define CRPGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CRPGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/crpga_pkg.sv =====
// Shared types and constants of the circular row padding gradient accumulator.
package crpga_pkg;

	localparam int ACC_DEPTH_DEF = 4096;
	localparam int VALUE_W       = 32;
	localparam int PROD_W        = 32;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 9;
	localparam int COL_W         = 10;
	localparam int ROW_W         = 10;
	localparam int CHAN_W        = 7;
	localparam int BATCH_W       = 5;

	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BATCHES,
		REG_CHANNELS,
		REG_ORIG_HEIGHT,
		REG_ORIG_WIDTH,
		REG_PAD_ROWS,
		REG_PAD_COLS,
		REG_ONE_SIDED
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0] batches;
		logic [6:0] channels;
		logic [8:0] orig_height;
		logic [8:0] orig_width;
		logic [7:0] pad_rows;
		logic [7:0] pad_cols;
		logic       one_sided;
	} cfg_t;

	typedef struct packed {
		logic                      req_type;
		logic signed [VALUE_W-1:0] grad_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] acc_value;
		logic                      last;
	} rsp_t;

	// Result of the index unit: flat index (accumulate) or drain length (drain).
	typedef struct packed {
		logic              done;
		logic              drain;
		logic              keep;
		logic [PROD_W-1:0] p;
	} idx_res_t;

endpackage

// ===== hdl/crpga_acc_mem.sv =====
// Accumulator store: one write port and one read port with registered read data.
module crpga_acc_mem import crpga_pkg::*; #(
	parameter int DEPTH = ACC_DEPTH_DEF,
	parameter int AW    = $clog2(ACC_DEPTH_DEF)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/crpga_index_unit.sv =====
// Position counters and the shared multiply-add sequencer for store indexes.
module crpga_index_unit import crpga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     start,
	input  logic     drain,
	output idx_res_t res
);

	typedef enum logic [1:0] {STEP_IDLE, STEP_ROW, STEP_COL} step_t;

	step_t              step_q;
	logic               done_q;
	logic               drain_q;
	logic               keep_q;
	logic [PROD_W-1:0]  p_q;
	logic [8:0]         h_q;
	logic [8:0]         w_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [BATCH_W-1:0] batch_q;

	logic signed [11:0] oh_s;
	logic signed [11:0] h_raw;
	logic signed [11:0] h_adj;
	logic               in_range;
	logic [PROD_W-1:0]  first_p;
	logic [10:0]        ph;
	logic [9:0]         pw;
	logic [10:0]        col_nx;
	logic [10:0]        row_nx;
	logic [7:0]         chan_nx;
	logic [5:0]         batch_nx;

	// Row shifted by the padding and wrapped once into the original height.
	always_comb begin
		oh_s  = $signed({3'b0, cfg.orig_height});
		h_raw = $signed({2'b0, row_q}) - $signed({4'b0, cfg.pad_rows});
		if (h_raw < 0) begin
			h_adj = h_raw + oh_s;
		end else if (h_raw >= oh_s) begin
			h_adj = h_raw - oh_s;
		end else begin
			h_adj = h_raw;
		end
		in_range = ({1'b0, cfg.orig_width} > col_q) && !h_adj[11] && (h_adj < oh_s);
	end

	// First multiply-add: batch by channels, plus channel when accumulating.
	always_comb begin
		if (drain) begin
			first_p = PROD_W'(cfg.batches) * PROD_W'(cfg.channels);
		end else begin
			first_p = PROD_W'(batch_q) * PROD_W'(cfg.channels) + PROD_W'(chan_q);
		end
	end

	// Padded extents and incremented counters.
	always_comb begin
		ph       = {2'b0, cfg.orig_height} +
			(cfg.one_sided ? {3'b0, cfg.pad_rows} : {2'b0, cfg.pad_rows, 1'b0});
		pw       = {1'b0, cfg.orig_width} + {2'b0, cfg.pad_cols};
		col_nx   = {1'b0, col_q} + 11'd1;
		row_nx   = {1'b0, row_q} + 11'd1;
		chan_nx  = {1'b0, chan_q} + 8'd1;
		batch_nx = {1'b0, batch_q} + 6'd1;
	end

	// Step control and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			done_q  <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
			chan_q  <= '0;
			batch_q <= '0;
		end else begin
			done_q <= (step_q == STEP_COL);
			case (step_q)
				STEP_IDLE: begin
					if (start) begin
						step_q <= STEP_ROW;
					end
				end
				STEP_ROW: begin
					step_q <= STEP_COL;
				end
				STEP_COL: begin
					step_q <= STEP_IDLE;
				end
				default: begin
					step_q <= STEP_IDLE;
				end
			endcase
			if (start && !drain) begin
				if (col_nx < {1'b0, pw}) begin
					col_q <= col_nx[COL_W-1:0];
				end else begin
					col_q <= '0;
					if (row_nx < ph) begin
						row_q <= row_nx[ROW_W-1:0];
					end else begin
						row_q <= '0;
						if (chan_nx < {1'b0, cfg.channels}) begin
							chan_q <= chan_nx[CHAN_W-1:0];
						end else begin
							chan_q <= '0;
							if (batch_nx < {1'b0, cfg.batches}) begin
								batch_q <= batch_nx[BATCH_W-1:0];
							end else begin
								batch_q <= '0;
							end
						end
					end
				end
			end
		end
	end

	// Multiply-add datapath: times height plus row, then times width plus column.
	always_ff @(posedge clk) begin
		if (start && step_q == STEP_IDLE) begin
			drain_q <= drain;
			keep_q  <= in_range;
			h_q     <= h_adj[8:0];
			w_q     <= col_q[8:0];
			p_q     <= first_p;
		end else if (step_q == STEP_ROW) begin
			p_q <= p_q * PROD_W'(cfg.orig_height) + (drain_q ? '0 : PROD_W'(h_q));
		end else if (step_q == STEP_COL) begin
			p_q <= p_q * PROD_W'(cfg.orig_width) + (drain_q ? '0 : PROD_W'(w_q));
		end
	end

	assign res = '{done: done_q, drain: drain_q, keep: keep_q, p: p_q};

endmodule

// ===== hdl/circular_row_pad_grad_accumulate_unit.sv =====
// Circular row padding backward pass: gradient accumulator, top level.
//
// Requests arrive on req (req_valid/req_ready). An accumulate request adds
// grad_value, saturating in Q16.16, into the store entry that the position
// counters select and gives no response; a drain request reads the next
// store entry, clears it and returns it on rsp (rsp_valid/rsp_ready) with
// last set on the final entry of the drain sequence.
// Every request passes acceptance, the index unit (two multiply-add steps on
// one shared multiplier and the hand-over), one memory read and one write
// back before the next request is accepted; a drain response is loaded into
// the output register by its write back, which sets rsp_valid.
// After reset a clearing pass writes all ACC_DEPTH entries, one entry
// a cycle, during which req_ready stays low; configuration writes are taken
// at any time. The response sits in an output register, so a new request is
// accepted while it waits; a drain that finds the register still occupied
// holds in its write cycle until the receiver takes the pending response.
`include "circular_row_pad_grad_accumulate_unit_assert.svh"
module circular_row_pad_grad_accumulate_unit import crpga_pkg::*; #(
	parameter int ACC_DEPTH = ACC_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(ACC_DEPTH);
	localparam int LW = $clog2(ACC_DEPTH + 1);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_READ, ST_WRITE} state_t;

	state_t              state_q;
	cfg_t                cfg_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       drain_idx_q;
	logic [AW-1:0]       nxt_idx_q;
	logic [AW-1:0]       addr_q;
	logic                wr_ok_q;
	logic                last_q;
	logic                drain_q;
	logic [VALUE_W-1:0]  g_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	idx_res_t            idx_res;
	logic                req_xfer;
	logic                slot_free;
	logic                rsp_load;
	logic [LW-1:0]       len;
	logic [LW-1:0]       d_idx;
	logic [LW-1:0]       d_next;
	logic                is_last;
	logic signed [VALUE_W:0] sum_w;
	logic [VALUE_W-1:0]  sat_val;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [VALUE_W-1:0]  mem_wdata;
	logic                mem_re;
	logic [VALUE_W-1:0]  rd_data;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_load  = (state_q == ST_WRITE) && drain_q && slot_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{batches: 5'd1, channels: 7'd1, orig_height: 9'd1, orig_width: 9'd1,
				pad_rows: 8'd0, pad_cols: 8'd0, one_sided: 1'b0};
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BATCHES:     cfg_q.batches     <= cfg_wdata[4:0];
				REG_CHANNELS:    cfg_q.channels    <= cfg_wdata[6:0];
				REG_ORIG_HEIGHT: cfg_q.orig_height <= cfg_wdata[8:0];
				REG_ORIG_WIDTH:  cfg_q.orig_width  <= cfg_wdata[8:0];
				REG_PAD_ROWS:    cfg_q.pad_rows    <= cfg_wdata[7:0];
				REG_PAD_COLS:    cfg_q.pad_cols    <= cfg_wdata[7:0];
				REG_ONE_SIDED:   cfg_q.one_sided   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	crpga_index_unit u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (req_xfer),
		.drain  (req.req_type),
		.res    (idx_res)
	);

	// Drain length capped at the store depth and at least one; wrapped drain index.
	always_comb begin
		if (idx_res.p > PROD_W'(ACC_DEPTH)) begin
			len = LW'(ACC_DEPTH);
		end else if (idx_res.p == '0) begin
			len = LW'(1);
		end else begin
			len = idx_res.p[LW-1:0];
		end
		d_idx   = (LW'(drain_idx_q) >= len) ? '0 : LW'(drain_idx_q);
		d_next  = d_idx + LW'(1);
		is_last = (d_next == len);
	end

	// Saturating add of the gradient to the stored sum.
	always_comb begin
		sum_w = $signed({rd_data[VALUE_W-1], rd_data}) + $signed({g_q[VALUE_W-1], g_q});
		if (sum_w[VALUE_W] != sum_w[VALUE_W-1]) begin
			sat_val = sum_w[VALUE_W] ? VAL_MIN : VAL_MAX;
		end else begin
			sat_val = sum_w[VALUE_W-1:0];
		end
	end

	// Memory port control: clearing pass, read, then write back.
	always_comb begin
		mem_re    = (state_q == ST_READ);
		mem_we    = (state_q == ST_CLEAR) ||
			(state_q == ST_WRITE && wr_ok_q && (!drain_q || slot_free));
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mem_wdata = (state_q == ST_WRITE && !drain_q) ? sat_val : '0;
	end

	crpga_acc_mem #(
		.DEPTH (ACC_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Request sequencer with the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			drain_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ACC_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (idx_res.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!drain_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						rsp_valid_q <= 1'b1;
						drain_idx_q <= nxt_idx_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload and resolved store address.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			g_q     <= req.grad_value;
			drain_q <= req.req_type;
		end
		if (state_q == ST_CALC && idx_res.done) begin
			if (idx_res.drain) begin
				addr_q    <= AW'(d_idx);
				nxt_idx_q <= is_last ? '0 : AW'(d_next);
				last_q    <= is_last;
				wr_ok_q   <= 1'b1;
			end else begin
				addr_q  <= idx_res.p[AW-1:0];
				wr_ok_q <= idx_res.keep && (idx_res.p < PROD_W'(ACC_DEPTH));
			end
		end
		if (rsp_load) begin
			rsp_q <= '{acc_value: rd_data, last: last_q};
		end
	end

	// A response is only ever loaded by a drain write-back.
	`CRPGA_ASSERT_IMP(a_rsp_from_drain, clk, arst_n, $rose(rsp_valid), $past(state_q == ST_WRITE) && drain_q)
	// The index unit only reports while the sequencer waits for it.
	`CRPGA_ASSERT_IMP(a_idx_done_in_calc, clk, arst_n, idx_res.done, state_q == ST_CALC)
	// Delivering the last entry of a drain restarts the drain index.
	`CRPGA_ASSERT_NXT(a_last_wraps, clk, arst_n, state_q == ST_WRITE && drain_q && slot_free && last_q, drain_idx_q == '0)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the circular row padding gradient accumulator.
`timescale 1ns / 1ps
module tb import crpga_pkg::*; ();

	localparam logic REQ_ACCUMULATE = 1'b0;
	localparam logic REQ_DRAIN      = 1'b1;
	localparam int   ITEM_TARGET    = 1550;
	localparam int   SETTLE_CYCLES  = 12;
	localparam int   WATCHDOG_LIMIT = 20000;
	localparam int   ACC_AW         = $clog2(ACC_DEPTH_DEF);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Shadow of the block: accumulator store, position counters and layout.
	logic signed [VALUE_W-1:0] shadow_acc [ACC_DEPTH_DEF];
	cfg_t                      shadow_cfg;
	int unsigned               col_pos, row_pos, chan_pos, batch_pos, drain_pos;
	rsp_t                      pending_drains [$];

	int  fail_count = 0;
	int  items_sent = 0;
	int  idle_cycles = 0;
	bit  no_idle = 1'b0;

	circular_row_pad_grad_accumulate_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Apply one accepted request to the shadow state; a drain queues its expected value.
	function automatic void accumulate_or_drain(req_t r);
		int unsigned oh, ow, pad, ph, pw, nb, nc;
		longint      row_h, flat, sum, span;
		rsp_t        drained;
		oh  = shadow_cfg.orig_height;
		ow  = shadow_cfg.orig_width;
		pad = shadow_cfg.pad_rows;
		nb  = shadow_cfg.batches;
		nc  = shadow_cfg.channels;
		ph  = oh + (shadow_cfg.one_sided ? pad : 2 * pad);
		pw  = ow + shadow_cfg.pad_cols;
		if (r.req_type == REQ_ACCUMULATE) begin
			// Shift the row up by the padding and wrap it once into the original height.
			row_h = longint'(row_pos) - longint'(pad);
			if (row_h < 0)
				row_h += longint'(oh);
			else if (row_h >= longint'(oh))
				row_h -= longint'(oh);
			if (col_pos < ow && row_h >= 0 && row_h < longint'(oh)) begin
				flat = ((longint'(batch_pos) * nc + chan_pos) * oh + row_h) * ow + col_pos;
				if (flat < ACC_DEPTH_DEF) begin
					sum = longint'(shadow_acc[flat[ACC_AW-1:0]]) +
						longint'($signed(r.grad_value));
					if (sum > longint'($signed(VAL_MAX)))
						sum = longint'($signed(VAL_MAX));
					if (sum < longint'($signed(VAL_MIN)))
						sum = longint'($signed(VAL_MIN));
					shadow_acc[flat[ACC_AW-1:0]] = sum[VALUE_W-1:0];
				end
			end
			// Step through column, row, channel and batch of the padded tensor.
			col_pos++;
			if (col_pos >= pw) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= ph) begin
					row_pos = 0;
					chan_pos++;
					if (chan_pos >= nc) begin
						chan_pos = 0;
						batch_pos++;
						if (batch_pos >= nb)
							batch_pos = 0;
					end
				end
			end
		end else begin
			span = longint'(nb) * nc * oh * ow;
			if (span > ACC_DEPTH_DEF)
				span = ACC_DEPTH_DEF;
			if (span == 0)
				span = 1;
			if (drain_pos >= span)
				drain_pos = 0;
			drained.last      = (drain_pos + 1 == span);
			drained.acc_value = shadow_acc[drain_pos[ACC_AW-1:0]];
			shadow_acc[drain_pos[ACC_AW-1:0]] = '0;
			drain_pos = drained.last ? 0 : drain_pos + 1;
			pending_drains.push_back(drained);
		end
	endfunction

	// Gradient values weighted towards the saturation bounds and small Q16.16 numbers.
	function automatic logic [VALUE_W-1:0] random_grad();
		case ($urandom_range(0, 7))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3: return $urandom();
			4: return '1;
			default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
		endcase
	endfunction

	// Offer one request and wait for its transfer.
	task automatic send_request(logic kind, logic [VALUE_W-1:0] grad);
		int   gap;
		req_t item;
		item.req_type   = kind;
		item.grad_value = grad;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		accumulate_or_drain(item);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop offering requests and let every expected drain arrive and the pipeline empty.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (pending_drains.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all seven layout registers while the block is idle.
	task automatic program_layout(int b, int c, int oh, int ow, int pr, int pc, int os);
		logic [CFG_DATA_W-1:0] setting [REG_BATCHES:REG_ONE_SIDED];
		cfg_reg_t              idx;
		settle_block();
		setting[REG_BATCHES]     = CFG_DATA_W'(b);
		setting[REG_CHANNELS]    = CFG_DATA_W'(c);
		setting[REG_ORIG_HEIGHT] = CFG_DATA_W'(oh);
		setting[REG_ORIG_WIDTH]  = CFG_DATA_W'(ow);
		setting[REG_PAD_ROWS]    = CFG_DATA_W'(pr);
		setting[REG_PAD_COLS]    = CFG_DATA_W'(pc);
		setting[REG_ONE_SIDED]   = CFG_DATA_W'(os);
		idx = REG_BATCHES;
		repeat (idx.num()) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx;
			cfg_wdata <= setting[idx];
			@(negedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		shadow_cfg.batches     = b[4:0];
		shadow_cfg.channels    = c[6:0];
		shadow_cfg.orig_height = oh[8:0];
		shadow_cfg.orig_width  = ow[8:0];
		shadow_cfg.pad_rows    = pr[7:0];
		shadow_cfg.pad_cols    = pc[7:0];
		shadow_cfg.one_sided   = os[0];
	endtask

	// A drain straight after reset sees the cleared store with the default layout.
	task automatic test_reset_drain();
		send_request(REQ_DRAIN, random_grad());
	endtask

	// With a single-entry layout every gradient lands in one entry, so sums clamp at both bounds.
	task automatic test_saturation();
		send_request(REQ_ACCUMULATE, VAL_MAX);
		send_request(REQ_ACCUMULATE, VAL_MAX);
		send_request(REQ_DRAIN, '0);
		send_request(REQ_ACCUMULATE, VAL_MIN);
		send_request(REQ_ACCUMULATE, '1);
		send_request(REQ_DRAIN, '0);
		send_request(REQ_ACCUMULATE, 32'h0001_0000);
		send_request(REQ_ACCUMULATE, '1);
		send_request(REQ_DRAIN, '0);
	endtask

	// A 2x2 image with one padded row on each side and a dropped column, then wrap and drain.
	task automatic test_circular_rows();
		program_layout(1, 1, 2, 2, 1, 1, 0);
		for (int k = 0; k < 12; k++)
			send_request(REQ_ACCUMULATE, (k + 1) << 16);
		repeat (4) send_request(REQ_DRAIN, '0);
	endtask

	// Largest layouts: capped drain length and dropped indices; then padding beyond the height.
	task automatic test_extreme_layouts();
		program_layout(16, 64, 256, 256, 255, 255, 0);
		repeat (250) send_request(REQ_ACCUMULATE, random_grad());
		repeat (6) send_request(REQ_DRAIN, '0);
		program_layout(16, 64, 256, 256, 255, 255, 1);
		repeat (150) send_request(REQ_ACCUMULATE, random_grad());
		repeat (4) send_request(REQ_DRAIN, '0);
		program_layout(1, 1, 1, 1, 255, 0, 0);
		repeat (270) send_request(REQ_ACCUMULATE, random_grad());
		repeat (3) send_request(REQ_DRAIN, '0);
	endtask

	// Mostly whole padded tensors followed by a full drain; some random mixes and large layouts.
	task automatic test_random_streams();
		int b, c, oh, ow, pr, pc, os, kind, ph, pw, tensor, pos, len, start;
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 7);
			if (kind == 0) begin
				b  = $urandom_range(1, 16);
				c  = $urandom_range(1, 64);
				oh = $urandom_range(1, 256);
				ow = $urandom_range(1, 256);
				pr = $urandom_range(0, 255);
				pc = $urandom_range(0, 255);
			end else begin
				b  = $urandom_range(1, 2);
				c  = $urandom_range(1, 3);
				oh = $urandom_range(1, 4);
				ow = $urandom_range(1, 4);
				pr = ($urandom_range(0, 9) == 0) ? oh + $urandom_range(1, 3)
					: $urandom_range(0, oh);
				pc = $urandom_range(0, 3);
			end
			os = $urandom_range(0, 1);
			program_layout(b, c, oh, ow, pr, pc, os);
			if (kind <= 1) begin
				// Random mix of accumulates and drains.
				repeat ($urandom_range(20, 140))
					send_request(($urandom_range(0, 3 + 4 * (kind == 0)) == 0)
						? REQ_DRAIN : REQ_ACCUMULATE, random_grad());
			end else begin
				// Finish the current tensor, add up to one more, then drain everything.
				ph = oh + (os ? pr : 2 * pr);
				pw = ow + pc;
				tensor = b * c * ph * pw;
				if (col_pos < pw && row_pos < ph && chan_pos < c && batch_pos < b)
					pos = ((batch_pos * c + chan_pos) * ph + row_pos) * pw + col_pos;
				else
					pos = 0;
				repeat (tensor * $urandom_range(1, 2) - pos)
					send_request(REQ_ACCUMULATE, random_grad());
				len = b * c * oh * ow;
				start = (drain_pos < len) ? drain_pos : 0;
				repeat (len - start) send_request(REQ_DRAIN, random_grad());
			end
		end
		no_idle = 1'b0;
	endtask

	// Response side: random stall before each transfer, then compare with the oldest expectation.
	initial begin
		int   stall;
		rsp_t want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (pending_drains.size() == 0) begin
				$error("unexpected response: acc_value %0d last %0b", rsp.acc_value, rsp.last);
				fail_count++;
			end else begin
				want = pending_drains.pop_front();
				if (rsp.acc_value !== want.acc_value) begin
					$error("acc_value: expected %0d, got %0d", want.acc_value, rsp.acc_value);
					fail_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, rsp.last);
					fail_count++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** circular_row_pad_grad_accumulate_unit: FAILED **");
			$finish;
		end
	end

	// Reset, then run the tests in turn and report.
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_BATCHES;
		cfg_wdata = '0;
		foreach (shadow_acc[i])
			shadow_acc[i] = '0;
		shadow_cfg             = '0;
		shadow_cfg.batches     = 5'd1;
		shadow_cfg.channels    = 7'd1;
		shadow_cfg.orig_height = 9'd1;
		shadow_cfg.orig_width  = 9'd1;
		col_pos   = 0;
		row_pos   = 0;
		chan_pos  = 0;
		batch_pos = 0;
		drain_pos = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_reset_drain();
		test_saturation();
		test_circular_rows();
		test_extreme_layouts();
		test_random_streams();
		settle_block();
		if (fail_count == 0)
			$display("** circular_row_pad_grad_accumulate_unit: PASSED **");
		else
			$display("** circular_row_pad_grad_accumulate_unit: FAILED **");
		$finish;
	end

endmodule
